// ===== hw/rtl/sba_pkg.sv =====
`default_nettype none

package sba_pkg;

  localparam int BR_W    = 24;
  localparam int MS_W    = 32;
  localparam int IVL_W   = 16;
  localparam int ACT_W   = 3;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_HELD    = 3'd0,
    ACT_SAME    = 3'd1,
    ACT_DEC     = 3'd2,
    ACT_INC     = 3'd3,
    ACT_RESTART = 3'd4
  } action_t;

  localparam logic CMD_EVAL    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [CIDX_W-1:0] REG_MAX_BR   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MIN_BR   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_INTERVAL = 3'd2;
  localparam logic [CIDX_W-1:0] REG_Q_THRESH = 3'd3;
  localparam logic [CIDX_W-1:0] REG_Q_LOW    = 3'd4;

  localparam logic [BR_W-1:0] INC_STEP_MIN = 24'd50;
  localparam logic [BR_W-1:0] INC_STEP_MAX = 24'd100;
  localparam logic [BR_W-1:0] DEC_STEP_MIN = 24'd100;

  localparam logic [IVL_W-1:0] INTERVAL_RST = 16'd1000;
  localparam logic [MS_W-1:0]  Q_THRESH_RST = 32'd500;
  localparam logic [MS_W-1:0]  Q_LOW_RST    = 32'd150;

  // ceil(2^27 / 10); (x * DIV10_MULT) >> 27 equals x / 10 for all x below 2^26.
  localparam logic [BR_W-1:0] DIV10_MULT  = 24'd13421773;
  localparam int              DIV10_SHIFT = 27;

endpackage

`default_nettype wire

// ===== hw/rtl/sba_if.sv =====
`default_nettype none

interface sba_in_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [sba_pkg::BR_W-1:0] in_bitrate;
  logic [sba_pkg::BR_W-1:0] out_bitrate;
  logic [sba_pkg::BR_W-1:0] net_bitrate;
  logic                     dropping;
  logic [sba_pkg::MS_W-1:0] queue_ms;
  logic [sba_pkg::MS_W-1:0] now_ms;

  modport source (output valid, command, in_bitrate, out_bitrate, net_bitrate, dropping,
                  queue_ms, now_ms, input ready);
  modport sink (input valid, command, in_bitrate, out_bitrate, net_bitrate, dropping,
                queue_ms, now_ms, output ready);
endinterface

interface sba_out_if;
  logic                     valid;
  logic                     ready;
  logic [sba_pkg::BR_W-1:0] recommended_bitrate;
  sba_pkg::action_t         action;

  modport source (output valid, recommended_bitrate, action, input ready);
  modport sink (input valid, recommended_bitrate, action, output ready);
endinterface

interface sba_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [sba_pkg::CIDX_W-1:0]  index;
  logic [sba_pkg::CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stream_bitrate_adapter.sv =====
// An accepted word passes the input register and then the output register.
// Throughput: one word per cycle unless the output stalls; the recommendation and
// hold-off registers are updated by a single stage that reads them for the next word.
// The configuration port is always ready and writes take effect at the next edge.
// Reset (rst_n low, synchronous) empties both stages, clears the hold-off window,
// sets the recommendation to zero and loads the register reset values.
`default_nettype none

module stream_bitrate_adapter (
  input  wire           clk,
  input  wire           rst_n,
  sba_in_if.sink        in_ch,
  sba_out_if.source     out_ch,
  sba_cfg_if.sink       cfg_ch
);

  // Configuration registers
  logic [sba_pkg::BR_W-1:0]  max_br_r;
  logic [sba_pkg::BR_W-1:0]  min_br_r;
  logic [sba_pkg::IVL_W-1:0] interval_r;
  logic [sba_pkg::MS_W-1:0]  q_thresh_r;
  logic [sba_pkg::MS_W-1:0]  q_low_r;

  // State
  logic [sba_pkg::BR_W-1:0]  rec_r, rec_nxt;
  logic                      hold_active_r, hold_active_nxt;
  logic [sba_pkg::MS_W-1:0]  hold_start_r, hold_start_nxt;
  logic                      hold_double_r, hold_double_nxt;

  // Input stage
  logic                      s0_valid_r;
  logic                      s0_cmd_r;
  logic [sba_pkg::BR_W-1:0]  s0_in_br_r;
  logic [sba_pkg::BR_W-1:0]  s0_out_br_r;
  logic [sba_pkg::BR_W-1:0]  s0_net_br_r;
  logic                      s0_drop_r;
  logic [sba_pkg::MS_W-1:0]  s0_queue_r;
  logic [sba_pkg::MS_W-1:0]  s0_now_r;

  // Output stage
  logic                      out_valid_r;
  logic [sba_pkg::BR_W-1:0]  out_rec_r;
  sba_pkg::action_t          out_act_r;
  sba_pkg::action_t          act_nxt;

  logic out_load;
  logic s0_fire;
  logic in_fire;

  assign out_load = !out_valid_r || out_ch.ready;
  assign s0_fire  = s0_valid_r && out_load;
  assign in_ch.ready = !s0_valid_r || out_load;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid               = out_valid_r;
  assign out_ch.recommended_bitrate = out_rec_r;
  assign out_ch.action              = out_act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_br_r   <= '0;
      min_br_r   <= '0;
      interval_r <= sba_pkg::INTERVAL_RST;
      q_thresh_r <= sba_pkg::Q_THRESH_RST;
      q_low_r    <= sba_pkg::Q_LOW_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        sba_pkg::REG_MAX_BR:   max_br_r   <= cfg_ch.data[sba_pkg::BR_W-1:0];
        sba_pkg::REG_MIN_BR:   min_br_r   <= cfg_ch.data[sba_pkg::BR_W-1:0];
        sba_pkg::REG_INTERVAL: interval_r <= cfg_ch.data[sba_pkg::IVL_W-1:0];
        sba_pkg::REG_Q_THRESH: q_thresh_r <= cfg_ch.data[sba_pkg::MS_W-1:0];
        sba_pkg::REG_Q_LOW:    q_low_r    <= cfg_ch.data[sba_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_cmd_r    <= in_ch.command;
      s0_in_br_r  <= in_ch.in_bitrate;
      s0_out_br_r <= in_ch.out_bitrate;
      s0_net_br_r <= in_ch.net_bitrate;
      s0_drop_r   <= in_ch.dropping;
      s0_queue_r  <= in_ch.queue_ms;
      s0_now_r    <= in_ch.now_ms;
    end
  end

  // Evaluation logic
  logic [sba_pkg::BR_W-1:0]    r0;
  logic [sba_pkg::IVL_W:0]     window;
  logic [sba_pkg::MS_W-1:0]    elapsed;
  logic                        held;
  logic [sba_pkg::BR_W-1:0]    v_lo;
  logic [sba_pkg::BR_W-1:0]    v;
  logic [sba_pkg::BR_W-1:0]    cap;
  logic [2*sba_pkg::BR_W-1:0]  v_prod;
  logic [sba_pkg::BR_W-1:0]    v_div10;
  logic                        dec_cond;
  logic [sba_pkg::BR_W:0]      dec_step;
  logic                        dec_small;
  logic [sba_pkg::BR_W-1:0]    dec_val;
  logic [sba_pkg::BR_W-1:0]    dec_res;
  logic                        inc_cond;
  logic [sba_pkg::BR_W-1:0]    inc_diff;
  logic [sba_pkg::BR_W-1:0]    inc_step;
  logic [sba_pkg::BR_W:0]      inc_sum;
  logic [sba_pkg::BR_W-1:0]    inc_res;

  always_comb begin
    r0      = (rec_r == '0) ? s0_in_br_r : rec_r;
    window  = hold_double_r ? {interval_r, 1'b0} : {1'b0, interval_r};
    elapsed = s0_now_r - hold_start_r;
    held    = hold_active_r &&
              (elapsed < {{(sba_pkg::MS_W - sba_pkg::IVL_W - 1){1'b0}}, window});

    v_lo = (s0_out_br_r < s0_net_br_r) ? s0_out_br_r : s0_net_br_r;
    v    = (v_lo < min_br_r) ? min_br_r : v_lo;
    cap  = (max_br_r < s0_net_br_r) ? max_br_r : s0_net_br_r;

    // floor((10r - 9v) / 10) = (r - v) + floor(v / 10)
    v_prod  = v * sba_pkg::DIV10_MULT;
    v_div10 = {{(sba_pkg::DIV10_SHIFT - sba_pkg::BR_W){1'b0}},
               v_prod[2*sba_pkg::BR_W-1:sba_pkg::DIV10_SHIFT]};
    dec_cond  = (s0_drop_r || (s0_queue_r > q_thresh_r)) && (r0 > v);
    dec_step  = {1'b0, r0 - v} + {1'b0, v_div10};
    dec_small = dec_step < {1'b0, sba_pkg::DEC_STEP_MIN};
    // With the full step the new rate is v - floor(v / 10).
    dec_val   = dec_small ? (r0 - sba_pkg::DEC_STEP_MIN) : (v - v_div10);
    if ((dec_small && (r0 < sba_pkg::DEC_STEP_MIN)) || (dec_val < min_br_r)) begin
      dec_res = min_br_r;
    end else begin
      dec_res = dec_val;
    end

    inc_cond = !s0_drop_r && (s0_queue_r < q_low_r) && (r0 < cap);
    inc_diff = s0_net_br_r - r0;
    if (inc_diff < sba_pkg::INC_STEP_MIN) begin
      inc_step = sba_pkg::INC_STEP_MIN;
    end else if (inc_diff > sba_pkg::INC_STEP_MAX) begin
      inc_step = sba_pkg::INC_STEP_MAX;
    end else begin
      inc_step = inc_diff;
    end
    inc_sum = {1'b0, r0} + {1'b0, inc_step};
    inc_res = (inc_sum > {1'b0, max_br_r}) ? max_br_r : inc_sum[sba_pkg::BR_W-1:0];
  end

  always_comb begin
    rec_nxt         = r0;
    act_nxt         = sba_pkg::ACT_SAME;
    hold_active_nxt = hold_active_r;
    hold_start_nxt  = hold_start_r;
    hold_double_nxt = hold_double_r;
    if (s0_cmd_r == sba_pkg::CMD_RESTART) begin
      rec_nxt = max_br_r;
      act_nxt = sba_pkg::ACT_RESTART;
    end else if (held) begin
      act_nxt = sba_pkg::ACT_HELD;
    end else begin
      hold_active_nxt = 1'b0;
      if (dec_cond) begin
        rec_nxt         = dec_res;
        act_nxt         = sba_pkg::ACT_DEC;
        hold_active_nxt = 1'b1;
        hold_start_nxt  = s0_now_r;
        hold_double_nxt = 1'b0;
      end else if (inc_cond) begin
        rec_nxt         = inc_res;
        act_nxt         = sba_pkg::ACT_INC;
        hold_active_nxt = 1'b1;
        hold_start_nxt  = s0_now_r;
        hold_double_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r         <= '0;
      hold_active_r <= 1'b0;
      hold_start_r  <= '0;
      hold_double_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (s0_fire) begin
        rec_r         <= rec_nxt;
        hold_active_r <= hold_active_nxt;
        hold_start_r  <= hold_start_nxt;
        hold_double_r <= hold_double_nxt;
      end
      if (out_load) begin
        out_valid_r <= s0_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      out_rec_r <= rec_nxt;
      out_act_r <= act_nxt;
    end
  end

`ifndef SYNTH
  // The output word always mirrors the recommendation it left behind.
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    s0_fire |=> (out_rec_r == rec_r))
    else $error("output word does not match recommendation state");

  a_dec_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_act_r == sba_pkg::ACT_DEC)) |-> (out_rec_r >= min_br_r))
    else $error("decrease went below the floor bitrate");

  a_inc_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_act_r == sba_pkg::ACT_INC)) |-> (out_rec_r <= max_br_r))
    else $error("increase went above the ceiling bitrate");

  a_change_starts_window: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_fire && ((act_nxt == sba_pkg::ACT_DEC) || (act_nxt == sba_pkg::ACT_INC)))
      |=> (hold_active_r && (hold_start_r == $past(s0_now_r))))
    else $error("rate change did not open a hold-off window");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s0_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled while a stage was free");
`endif

endmodule

`default_nettype wire
